FILE: sv/bws_pkg.sv
// Package: shared constants, types and helpers for the band-limited wavetable sample block.
`default_nettype none
package bws_pkg;
    localparam logic [1:0] WAVE_RECT = 2'd0;
    localparam logic [1:0] WAVE_SAW  = 2'd1;
    localparam logic [1:0] WAVE_TRI  = 2'd2;
    // Unknown waveform: sums nothing
    localparam logic [1:0] WAVE_NONE = 2'd3;

    localparam logic [0:0] REG_WAVEFORM_KIND  = 1'b0;
    localparam logic [0:0] REG_HARMONIC_LIMIT = 1'b1;

    localparam logic [31:0] AMP_RECT = 32'd1367130552;
    localparam logic [31:0] AMP_SAW  = 32'd683565276;
    localparam logic [31:0] AMP_TRI  = 32'd870342340;
    localparam logic [31:0] PI_Q22   = 32'd13176795;
    localparam logic [31:0] Q30_ONE  = 32'd1073741824;

    // Taylor coefficients for the quarter-wave sine, highest order first
    localparam logic signed [31:0] SIN_POLY [6] = '{
        -32'sd3864, 32'sd172272, -32'sd5026995,
        32'sd85569306, -32'sd693598668, 32'sd1686629713
    };

    // Operation selector for the shared multiplier
    typedef enum logic [1:0] {
        MUL_POLY,
        MUL_COEF,
        MUL_TERM
    } mul_op_t;

    // Control from the sequencer to the divider
    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [63:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quot;
    } div_rsp_t;
endpackage
`default_nettype wire

FILE: sv/bws_div.sv
// Restoring divider: one quotient bit per cycle, 64-bit operands.
`default_nettype none
module bws_div (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire bws_pkg::div_req_t req,
    output bws_pkg::div_rsp_t     rsp
);
    logic [63:0] rem_reg, rem_next;
    logic [63:0] quot_reg, quot_next;
    logic [63:0] den_reg, den_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [64:0] trial;
    logic [64:0] shifted;

    // Shift in one dividend bit and subtract if it fits
    always_comb
    begin
        rem_next  = rem_reg;
        quot_next = quot_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, quot_reg[63]};
        trial     = shifted - {1'b0, den_reg};
        if (req.start)
        begin
            rem_next  = '0;
            quot_next = req.num;
            den_next  = req.den;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[64])
            begin
                rem_next  = trial[63:0];
                quot_next = {quot_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted[63:0];
                quot_next = {quot_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        den_reg  <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
endmodule
`default_nettype wire

FILE: sv/bandlimited_wavetable_sample.sv
// Top level: band-limited wavetable sample generator with a shared divider and multiplier.
//
// Usage: present sample_index with in_valid; the transfer happens when in_stall is low.
// in_stall stays high while one sample is being computed. For every harmonic above
// the first the sequencer runs the shared 64-step divider for the sigma phase, the
// sigma quotient and the amplitude, and the shared 32x32 multiplier for two
// seven-step sine polynomials and the products; the first harmonic needs no sigma.
// The table phase is a shift, as the table length must be a power of two.
// The unknown waveform skips the harmonics. No new input is taken before the
// current sample has left the sequencer.
// The result sits in an output register with out_valid until it is transferred
// while out_stall is low; the next input may be taken and computed meanwhile, and
// the finished sample waits in the sequencer until the output register is free.
// Reset clears the registers to a rectangle with limit 20 and leaves the block
// idle with no result pending. Configuration is written through cfg_we, cfg_index
// and cfg_data; the user must write it only while idle, the block does not enforce it.
`default_nettype none
module bandlimited_wavetable_sample #(
    parameter int TABLE_LEN   = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [0:0]                    cfg_index,
    input  wire logic [9:0]                    cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [9:0]                    sample_index,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0]      sample_value,
    output logic                               clipped
);
    localparam int SH = 32 - SAMPLE_BITS;
    localparam int TAB_LOG = $clog2(TABLE_LEN);
    localparam logic signed [63:0] HI = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
    localparam logic signed [63:0] LO = -HI - 64'sd1;

    typedef enum logic [3:0] {
        S_IDLE, S_HSTART, S_PH_WAIT, S_POLY, S_SIGDIV, S_SIGWAIT,
        S_AMPDIV, S_AMPWAIT, S_COEF, S_TPH, S_TERM, S_NEXT, S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic [1:0]  kind_reg;
    logic [9:0]  limit_reg;
    logic [9:0]  k_reg, k_next;
    logic [9:0]  h_reg, h_next;
    logic        tsin_reg, tsin_next;          // 0 sigma sine, 1 table sine
    logic [2:0]  pstep_reg, pstep_next;
    logic [1:0]  quad_reg, quad_next;
    logic [31:0] x_reg, x_next, x2_reg, x2_next;
    logic signed [63:0] r_reg, r_next;
    logic [63:0] sigma_reg, sigma_next, amp_reg, amp_next, coef_reg, coef_next;
    logic signed [63:0] acc_reg, acc_next;
    logic signed [SAMPLE_BITS-1:0] y_reg, y_next;
    logic        clip_reg, clip_next, ov_reg, ov_next;
    bws_pkg::div_req_t dreq;
    bws_pkg::div_rsp_t drsp;

    // Shared multiplier
    logic [31:0] ma, mb;
    logic [63:0] mp;
    assign mp = {32'd0, ma} * {32'd0, mb};

    bws_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    logic [19:0] hk;
    logic [19:0] hkm;
    logic [31:0] tph;
    logic [63:0] rmag;
    logic [63:0] hh;
    logic [31:0] pq;
    logic [31:0] xraw;
    logic        tneg;
    logic signed [63:0] rnd;
    logic [63:0] poly_p;
    logic signed [63:0] poly_v;

    always_comb
    begin
        state_next = state_reg;
        k_next = k_reg; h_next = h_reg; tsin_next = tsin_reg;
        pstep_next = pstep_reg; quad_next = quad_reg;
        x_next = x_reg; x2_next = x2_reg; r_next = r_reg;
        sigma_next = sigma_reg; amp_next = amp_reg; coef_next = coef_reg;
        acc_next = acc_reg; y_next = y_reg; clip_next = clip_reg; ov_next = ov_reg;
        dreq = '0;
        ma = '0; mb = '0;
        hk = {10'd0, h_reg} * {10'd0, k_reg};
        hkm = hk & 20'(TABLE_LEN - 1);
        tph = 32'({hkm, 32'd0} >> TAB_LOG);
        hh = {54'd0, h_reg} * {54'd0, h_reg};
        rmag = r_reg[63] ? 64'(-r_reg) : 64'(r_reg);
        pq = drsp.quot[31:0];
        xraw = {2'b00, pq[29:0]};
        tneg = 1'b0;
        rnd = '0;
        poly_p = '0;
        poly_v = '0;
        // Free the output register on its transfer
        if (ov_reg && !out_stall)
            ov_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    k_next = 10'(sample_index & 10'(TABLE_LEN - 1));
                    h_next = 10'd1;
                    acc_next = '0;
                    state_next = (kind_reg == bws_pkg::WAVE_NONE) ? S_DONE : S_HSTART;
                end
            end
            S_HSTART:
            begin
                if (h_reg >= limit_reg)
                    state_next = S_DONE;
                else if (h_reg == 10'd1)
                begin
                    sigma_next = 64'(bws_pkg::Q30_ONE);
                    state_next = S_AMPDIV;
                end
                else
                begin
                    // Sigma phase: (h-1)/(2*limit) turns
                    dreq.start = 1'b1;
                    dreq.num = {22'd0, 10'(h_reg - 10'd1), 32'd0};
                    dreq.den = {53'd0, limit_reg, 1'b0};
                    tsin_next = 1'b0;
                    state_next = S_PH_WAIT;
                end
            end
            S_PH_WAIT:
            begin
                if (drsp.done)
                begin
                    quad_next = pq[31:30];
                    x_next = pq[30] ? (bws_pkg::Q30_ONE - xraw) : xraw;
                    r_next = 64'(bws_pkg::SIN_POLY[0]);
                    pstep_next = 3'd0;
                    state_next = S_POLY;
                end
            end
            S_POLY:
            begin
                // Step 0 squares x, steps 1..5 Horner, step 6 times x
                if (pstep_reg == 3'd0)
                begin
                    ma = x_reg; mb = x_reg;
                    x2_next = 32'(mp >> 30);
                    pstep_next = 3'd1;
                end
                else
                begin
                    ma = rmag[31:0];
                    mb = (pstep_reg == 3'd6) ? x_reg : x2_reg;
                    poly_p = mp >> 30;
                    poly_v = r_reg[63] ? -$signed(poly_p) : $signed(poly_p);
                    if (pstep_reg == 3'd6)
                    begin
                        r_next = quad_reg[1] ? -poly_v : poly_v;
                        state_next = tsin_reg ? S_TERM : S_SIGDIV;
                    end
                    else
                    begin
                        r_next = 64'(bws_pkg::SIN_POLY[pstep_reg]) + poly_v;
                        pstep_next = pstep_reg + 3'd1;
                    end
                end
            end
            S_SIGDIV:
            begin
                ma = r_reg[31:0]; mb = {22'd0, limit_reg};
                dreq.start = 1'b1;
                dreq.num = mp << 22;
                dreq.den = {54'd0, 10'(h_reg - 10'd1)} * {32'd0, bws_pkg::PI_Q22};
                state_next = S_SIGWAIT;
            end
            S_SIGWAIT:
            begin
                if (drsp.done)
                begin
                    sigma_next = drsp.quot;
                    state_next = S_AMPDIV;
                end
            end
            S_AMPDIV:
            begin
                dreq.start = 1'b1;
                unique case (kind_reg)
                    bws_pkg::WAVE_RECT: begin dreq.num = 64'(bws_pkg::AMP_RECT);
                                              dreq.den = {54'd0, h_reg}; end
                    bws_pkg::WAVE_SAW:  begin dreq.num = 64'(bws_pkg::AMP_SAW);
                                              dreq.den = {54'd0, h_reg}; end
                    default:            begin dreq.num = 64'(bws_pkg::AMP_TRI);
                                              dreq.den = hh; end
                endcase
                state_next = S_AMPWAIT;
            end
            S_AMPWAIT:
            begin
                if (drsp.done)
                begin
                    amp_next = drsp.quot;
                    state_next = S_COEF;
                end
            end
            S_COEF:
            begin
                ma = sigma_reg[31:0]; mb = amp_reg[31:0];
                coef_next = mp >> 30;
                state_next = S_TPH;
            end
            S_TPH:
            begin
                // Table phase: the fraction of a turn is a shift of (h*k mod length)
                quad_next = tph[31:30];
                x_next = tph[30] ? (bws_pkg::Q30_ONE - {2'b00, tph[29:0]})
                                 : {2'b00, tph[29:0]};
                r_next = 64'(bws_pkg::SIN_POLY[0]);
                pstep_next = 3'd0;
                tsin_next = 1'b1;
                state_next = S_POLY;
            end
            S_TERM:
            begin
                ma = coef_reg[31:0]; mb = rmag[31:0];
                tneg = r_reg[63];
                if (kind_reg == bws_pkg::WAVE_SAW && !h_reg[0]) tneg = !tneg;
                if (kind_reg == bws_pkg::WAVE_TRI && h_reg[1:0] == 2'd3) tneg = !tneg;
                acc_next = tneg ? acc_reg - $signed(mp >> 29) : acc_reg + $signed(mp >> 29);
                state_next = S_NEXT;
            end
            S_NEXT:
            begin
                h_next = h_reg + ((kind_reg == bws_pkg::WAVE_SAW) ? 10'd1 : 10'd2);
                // Stop on wrap of the harmonic counter
                state_next = (h_next < h_reg) ? S_DONE : S_HSTART;
            end
            S_DONE:
            begin
                // Hold the finished sample until the output register is free
                if (!ov_reg || !out_stall)
                begin
                    rnd = (SH > 0) ? ((acc_reg + (64'sd1 <<< (SH > 0 ? SH - 1 : 0))) >>> SH)
                                   : acc_reg;
                    clip_next = 1'b0;
                    if (rnd > HI) begin y_next = SAMPLE_BITS'(HI); clip_next = 1'b1; end
                    else if (rnd < LO) begin y_next = SAMPLE_BITS'(LO); clip_next = 1'b1; end
                    else y_next = SAMPLE_BITS'(rnd);
                    ov_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Hold state, configuration and the output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            kind_reg  <= 2'd0;
            limit_reg <= 10'd20;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    bws_pkg::REG_WAVEFORM_KIND:  kind_reg  <= cfg_data[1:0];
                    bws_pkg::REG_HARMONIC_LIMIT: limit_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg <= k_next; h_reg <= h_next; tsin_reg <= tsin_next;
        pstep_reg <= pstep_next; quad_reg <= quad_next;
        x_reg <= x_next; x2_reg <= x2_next; r_reg <= r_next;
        sigma_reg <= sigma_next; amp_reg <= amp_next; coef_reg <= coef_next;
        acc_reg <= acc_next; y_reg <= y_next; clip_reg <= clip_next;
    end

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = ov_reg;
    assign sample_value = y_reg;
    assign clipped      = clip_reg;

`ifndef NO_ASSERTIONS
    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall) else $error("input taken while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(sample_value)))
        else $error("stalled result changed");
    a_clip_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && clipped) |-> (sample_value == SAMPLE_BITS'(HI)
        || sample_value == SAMPLE_BITS'(LO))) else $error("clip without saturation");
`endif
endmodule
`default_nettype wire

FILE: test/tb_top.sv
// Testbench for the band-limited wavetable sample block: random traffic, stalls and self-check.
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned TAB_LEN = 1024;
    localparam int CYCLE_LIMIT = 40000000;
    localparam int LONG_HOLD = 4000;

    typedef struct packed {
        logic signed [15:0] value;
        logic               clip;
    } wave_out_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [9:0]  cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [9:0]  sample_index;
    logic        out_valid;
    logic        out_stall;
    logic signed [15:0] sample_value;
    logic        clipped;

    // Shadow of the configuration registers
    logic [1:0]  kind_shadow;
    logic [9:0]  limit_shadow;

    logic [9:0]  index_q [$];
    wave_out_t   sample_exp_q [$];

    int errors;
    int sent;
    int checked;
    int clip_seen;
    int cycles;
    int burst_left;
    int gap_left;
    int hold_left;
    int stall_span;
    bit stall_busy;
    bit hold_req;

    bandlimited_wavetable_sample dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample_index (sample_index),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sample_value (sample_value),
        .clipped      (clipped)
    );

    // Clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Signed value times unsigned Q30, truncated toward zero
    function automatic longint scale_q30(input longint a, input longint unsigned b);
        longint unsigned mag;
        longint unsigned p;
        mag = (a < 0) ? longint'(-a) : longint'(a);
        p = (mag * b) >> 30;
        return (a < 0) ? -longint'(p) : longint'(p);
    endfunction

    // Q30 sine of num/den turns
    function automatic longint sine_q30(input longint unsigned num,
                                        input longint unsigned den);
        longint unsigned p;
        longint unsigned quad;
        longint unsigned x;
        longint unsigned x2;
        longint r;
        p = (num << 32) / den;
        quad = (p >> 30) & 64'd3;
        x = p & (64'(bws_pkg::Q30_ONE) - 64'd1);
        if (quad[0])
            x = 64'(bws_pkg::Q30_ONE) - x;
        x2 = (x * x) >> 30;
        r = longint'(bws_pkg::SIN_POLY[0]);
        for (int i = 1; i < 6; i++)
            r = longint'(bws_pkg::SIN_POLY[i]) + scale_q30(r, x2);
        r = scale_q30(r, x);
        return quad[1] ? -r : r;
    endfunction

    // Expected sample for a table position under the shadow configuration
    function automatic wave_out_t wave_sample(input logic [9:0] idx);
        longint unsigned k;
        longint unsigned lim;
        longint unsigned stp;
        longint unsigned sigma;
        longint unsigned amp;
        longint unsigned coef;
        longint unsigned mag;
        longint unsigned sv;
        longint s;
        longint acc;
        longint y;
        bit neg;
        wave_out_t res;
        k = 64'(idx) % TAB_LEN;
        lim = 64'(limit_shadow);
        stp = (kind_shadow == bws_pkg::WAVE_SAW) ? 64'd1 : 64'd2;
        acc = 0;
        if (kind_shadow != bws_pkg::WAVE_NONE)
        begin
            for (longint unsigned h = 1; h < lim; h += stp)
            begin
                if (h == 1)
                    sigma = 64'(bws_pkg::Q30_ONE);
                else
                begin
                    sv = longint'(sine_q30(h - 1, 2 * lim));
                    sigma = ((sv * lim) << 22) / ((h - 1) * 64'(bws_pkg::PI_Q22));
                end
                if (kind_shadow == bws_pkg::WAVE_RECT)
                    amp = 64'(bws_pkg::AMP_RECT) / h;
                else if (kind_shadow == bws_pkg::WAVE_SAW)
                    amp = 64'(bws_pkg::AMP_SAW) / h;
                else
                    amp = 64'(bws_pkg::AMP_TRI) / (h * h);
                coef = (sigma * amp) >> 30;
                s = sine_q30((h * k) % TAB_LEN, TAB_LEN);
                neg = s < 0;
                mag = (coef * longint'(neg ? -s : s)) >> 29;
                if (kind_shadow == bws_pkg::WAVE_SAW && h[0] == 1'b0)
                    neg = !neg;
                if (kind_shadow == bws_pkg::WAVE_TRI && h[1:0] == 2'd3)
                    neg = !neg;
                acc += neg ? -longint'(mag) : longint'(mag);
            end
        end
        // Round halves upward, then saturate
        y = (acc + 64'sd32768) >>> 16;
        res.clip = 1'b0;
        if (y > 32767)
        begin
            y = 32767;
            res.clip = 1'b1;
        end
        else if (y < -32768)
        begin
            y = -32768;
            res.clip = 1'b1;
        end
        res.value = 16'(y);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s at result %0d: got %0d, expected %0d",
                 what, checked, got, want);
        errors++;
    endtask

    // Sender: bursts of transfers with random gaps in between
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            sample_index <= '0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                sample_exp_q.push_back(wave_sample(sample_index));
                sent++;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (index_q.size() > 0)
                begin
                    in_valid <= 1'b1;
                    sample_index <= index_q.pop_front();
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 8);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 400);
                    end
                    else
                        burst_left--;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: check each transfer, stall on its own pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left = 0;
            stall_span = 0;
            stall_busy = 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (sample_exp_q.size() == 0)
                begin
                    report_mismatch("unexpected result", sample_value, 0);
                end
                else
                begin
                    wave_out_t want;
                    want = sample_exp_q.pop_front();
                    if (sample_value !== want.value)
                        report_mismatch("sample_value", sample_value, want.value);
                    if (clipped !== want.clip)
                        report_mismatch("clipped", clipped, want.clip);
                    if (want.clip)
                        clip_seen++;
                end
                checked++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = LONG_HOLD;
                out_stall <= 1'b1;
            end
            else
            begin
                if (stall_span == 0)
                begin
                    stall_span = $urandom_range(50, 2000);
                    stall_busy = $urandom_range(0, 1);
                end
                stall_span--;
                out_stall <= stall_busy ? ($urandom_range(0, 2) != 0) : 1'b0;
            end
        end
    end

    // Timeout
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [0:0] idx, input logic [9:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        if (idx == bws_pkg::REG_WAVEFORM_KIND)
            kind_shadow = data[1:0];
        else
            limit_shadow = data;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Hold until every pending transfer has been answered
    task automatic drain();
        while (index_q.size() > 0 || in_valid || sample_exp_q.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic run_phase(input logic [1:0] kind, input logic [9:0] lim,
                             input int count);
        write_reg(bws_pkg::REG_WAVEFORM_KIND, 10'(kind));
        write_reg(bws_pkg::REG_HARMONIC_LIMIT, lim);
        for (int i = 0; i < count; i++)
            index_q.push_back(10'($urandom_range(0, 1023)));
        drain();
    endtask

    initial
    begin
        logic [1:0] kind;
        logic [9:0] lim;
        errors = 0;
        sent = 0;
        checked = 0;
        clip_seen = 0;
        cycles = 0;
        hold_req = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        kind_shadow = bws_pkg::WAVE_RECT;
        limit_shadow = 10'd20;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset configuration: edges, quarter points and an eighth point of the table
        index_q = '{10'd0, 10'd1023, 10'd1, 10'd256, 10'd512, 10'd768, 10'd128};
        drain();
        // Smallest limits, unknown waveform, largest limits
        write_reg(bws_pkg::REG_WAVEFORM_KIND, 10'(bws_pkg::WAVE_SAW));
        write_reg(bws_pkg::REG_HARMONIC_LIMIT, 10'd2);
        index_q = '{10'd256, 10'd768, 10'd1023};
        drain();
        run_phase(bws_pkg::WAVE_TRI, 10'd3, 2);
        run_phase(bws_pkg::WAVE_NONE, 10'd20, 2);
        run_phase(bws_pkg::WAVE_RECT, 10'd0, 1);
        run_phase(bws_pkg::WAVE_RECT, 10'd1, 1);
        write_reg(bws_pkg::REG_HARMONIC_LIMIT, 10'd512);
        index_q = '{10'd256, 10'd5};
        drain();
        run_phase(bws_pkg::WAVE_TRI, 10'd1023, 1);
        write_reg(bws_pkg::REG_WAVEFORM_KIND, 10'(bws_pkg::WAVE_SAW));
        write_reg(bws_pkg::REG_HARMONIC_LIMIT, 10'd1023);
        index_q = '{10'd511};
        drain();
        write_reg(bws_pkg::REG_HARMONIC_LIMIT, 10'd513);
        index_q = '{10'd3, 10'd1020};
        drain();

        // Random phases, mostly small limits; one short-limit phase with a long
        // receiver hold so that the block fills and stalls its input
        for (int p = 0; p < 28; p++)
        begin
            kind = ($urandom_range(0, 9) == 0) ? bws_pkg::WAVE_NONE
                                               : 2'($urandom_range(0, 2));
            lim = ($urandom_range(0, 7) == 0) ? 10'($urandom_range(13, 64))
                                              : 10'($urandom_range(0, 12));
            if (p == 5)
            begin
                kind = bws_pkg::WAVE_RECT;
                lim = 10'd6;
                @(negedge clk);
                hold_req = 1'b1;
            end
            run_phase(kind, lim, 20);
        end

        repeat (50) @(posedge clk);
        $display("Ran %0d samples over all waveforms and limits 0 to 1023, %0d clipped,",
                 sent, clip_seen);
        $display("with random sender gaps, receiver stalls and one long hold.");
        if (errors == 0 && sample_exp_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
`default_nettype wire

FILE: filelist.f
sv/bws_pkg.sv
sv/bws_div.sv
sv/bandlimited_wavetable_sample.sv
test/tb_top.sv
